// ===== src/mme_pkg.sv =====
// ----------------------------------------------------------------------------
// mme_pkg
// Shared widths and reset values for the modular exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none

package mme_pkg;

  // width of base, exponent, modulus and result
  localparam int DATA_W = 31;

  // modulus after reset
  localparam logic [DATA_W-1:0] MOD_RESET = 31'd1000000007;

endpackage

`default_nettype wire

// ===== src/mme_mulmod.sv =====
// ----------------------------------------------------------------------------
// mme_mulmod
// Bit-serial modular multiplier: a * b mod m, one bit of b per cycle, MSB
// first. Operand a must be below m; b may hold any bit pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_mulmod #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] product
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;
  localparam logic [CW-1:0] LAST_CNT = CW'(W - 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  a_reg;
  logic [W-1:0]  b_sh;
  logic [W-1:0]  r;
  logic [W-1:0]  r_next;

  logic [W:0] dbl;
  logic [W:0] m_ext;
  logic [W-1:0] dbl_red;
  logic [W:0] sum;

  // one step: r = 2r mod m, then add a when the current bit of b is set
  always_comb begin
    m_ext   = {1'b0, m};
    dbl     = {r, 1'b0};
    dbl_red = (dbl >= m_ext) ? W'(dbl - m_ext) : W'(dbl);
    sum     = {1'b0, dbl_red} + (b_sh[W-1] ? {1'b0, a_reg} : '0);
    r_next  = (sum >= m_ext) ? W'(sum - m_ext) : W'(sum);
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= LAST_CNT;
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // operand shift register and partial remainder
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      a_reg <= a;
      b_sh  <= b;
      r     <= '0;
    end else if (busy) begin
      b_sh <= {b_sh[W-2:0], 1'b0};
      r    <= r_next;
    end
  end

  assign product = r;

endmodule

`default_nettype wire

// ===== src/mme_seq.sv =====
// ----------------------------------------------------------------------------
// mme_seq
// Square-and-multiply sequencer: scans the exponent from its low bit, drives
// the shared multiplier and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_seq #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [W-1:0] m,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [W-1:0] base,
  input  logic [W-1:0] exponent,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [W-1:0] result,
  output logic         mul_start,
  output logic [W-1:0] mul_a,
  output logic [W-1:0] mul_b,
  input  logic         mul_done,
  input  logic [W-1:0] mul_product
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RED  = 6'b000010,
    S_DEC  = 6'b000100,
    S_MUL  = 6'b001000,
    S_SQR  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  localparam logic [W-1:0] ONE = W'(1);
  localparam logic [W-1:0] TWO = W'(2);

  state_t       state;
  logic [W-1:0] acc;
  logic [W-1:0] pw;
  logic [W-1:0] exp_sh;
  logic         m_small;
  logic         exp_rest;

  assign m_small  = (m < TWO);
  assign exp_rest = (exp_sh[W-1:1] != '0);
  assign in_stall = (state != S_IDLE);

  // multiplier requests
  always_comb begin
    mul_start = 1'b0;
    mul_a     = acc;
    mul_b     = pw;
    unique case (state)
      S_IDLE: begin
        // reduce the base: 1 * base mod m
        if (in_valid && !m_small) begin
          mul_start = 1'b1;
          mul_a     = ONE;
          mul_b     = base;
        end
      end
      S_DEC: begin
        if (exp_sh[0]) begin
          mul_start = 1'b1;
        end else if (exp_rest) begin
          mul_start = 1'b1;
          mul_a     = pw;
        end
      end
      S_RED, S_MUL, S_SQR, S_OUT: begin
        mul_start = 1'b0;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // result handshake: load a new item or drop the taken one
      if (state == S_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= m_small ? S_OUT : S_RED;
          end
        end
        S_RED, S_MUL, S_SQR: begin
          if (mul_done) begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          if (exp_sh[0]) begin
            state <= S_MUL;
          end else if (exp_rest) begin
            state <= S_SQR;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          exp_sh <= exponent;
          acc    <= m_small ? '0 : ONE;
        end
      end
      S_RED, S_SQR: begin
        if (mul_done) begin
          pw <= mul_product;
        end
      end
      S_MUL: begin
        // bit consumed: clear it so the next decision squares or finishes
        if (mul_done) begin
          acc       <= mul_product;
          exp_sh[0] <= 1'b0;
        end
      end
      S_DEC: begin
        if (!exp_sh[0]) begin
          exp_sh <= {1'b0, exp_sh[W-1:1]};
        end
      end
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          result <= acc;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/modular_exponentiation.sv =====
// Each item runs a base reduction, then one modular multiply per set bit of the
// exponent and as many squarings as its bit length minus one, each multiply
// followed by a next-step decision; a modulus below two skips all multiplies.
// One item at a time, taken the cycle after the result moves into the output
// register. Reset is synchronous, active high, clears the control state and
// loads the modulus with 1000000007.
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply modulo a configured modulus, built on one
// shared bit-serial modular multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation
  import mme_pkg::*;
#(
  parameter int W = DATA_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         modulus_we,
  input  logic [W-1:0] modulus_wdata,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [W-1:0] base,
  input  logic [W-1:0] exponent,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [W-1:0] result
);

  logic [W-1:0] modulus;
  logic         mul_start;
  logic [W-1:0] mul_a;
  logic [W-1:0] mul_b;
  logic         mul_done;
  logic [W-1:0] mul_product;

  // modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= W'(MOD_RESET);
    end else if (modulus_we) begin
      modulus <= modulus_wdata;
    end
  end

  mme_seq #(.W(W)) u_seq (
    .clk         (clk),
    .rst         (rst),
    .m           (modulus),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .base        (base),
    .exponent    (exponent),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result      (result),
    .mul_start   (mul_start),
    .mul_a       (mul_a),
    .mul_b       (mul_b),
    .mul_done    (mul_done),
    .mul_product (mul_product)
  );

  mme_mulmod #(.W(W)) u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .m       (modulus),
    .done    (mul_done),
    .product (mul_product)
  );

endmodule

`default_nettype wire

// ===== src/mme_checker.sv =====
// ----------------------------------------------------------------------------
// mme_checker
// Port-level checks for the modular exponentiation block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_checker
  import mme_pkg::*;
#(
  parameter int W = DATA_W
) (
  input logic         clk,
  input logic         rst,
  input logic         modulus_we,
  input logic [W-1:0] modulus_wdata,
  input logic         in_valid,
  input logic         in_stall,
  input logic         out_valid,
  input logic         out_stall,
  input logic [W-1:0] result
);

  localparam logic [W-1:0] TWO = W'(2);

  logic [W-1:0] mod_shadow;

  // copy of the modulus as seen on the ports
  always_ff @(posedge clk) begin
    if (rst) begin
      mod_shadow <= W'(MOD_RESET);
    end else if (modulus_we) begin
      mod_shadow <= modulus_wdata;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result))
    else $error("result changed while stalled");

  // an accepted item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an item");

  // result is always reduced
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((mod_shadow < TWO) ? (result == '0) : (result < mod_shadow)))
    else $error("result not below the modulus");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind modular_exponentiation mme_checker #(.W(W)) u_mme_checker (
  .clk           (clk),
  .rst           (rst),
  .modulus_we    (modulus_we),
  .modulus_wdata (modulus_wdata),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .result        (result)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives base/exponent items into the modular exponentiation block under a
// series of modulus settings (reset value, both ends of the range, zero and
// one, small and large values) and checks every result against a software
// square-and-multiply computed with 64-bit intermediates. Both handshake
// sides idle at random, with quiet stretches in between.
// ----------------------------------------------------------------------------

module tb_top;
  import mme_pkg::*;

  typedef bit [DATA_W-1:0] word_t;

  // expected powers, oldest first, and the modulus they are computed under
  class power_board;
    word_t       modulus;
    word_t       expected_q[$];
    int unsigned errors;

    function new();
      modulus = MOD_RESET;
      errors  = 0;
    endfunction

    function void set_modulus(word_t value);
      modulus = value;
    endfunction

    // right-to-left square-and-multiply
    function word_t expected_power(word_t b, word_t e);
      longint unsigned m;
      longint unsigned acc;
      longint unsigned pw;
      word_t           rest;
      m    = modulus;
      acc  = 1;
      rest = e;
      if (m < 2) return '0;
      pw = b % m;
      while (rest != 0) begin
        if (rest[0]) acc = (acc * pw) % m;
        rest = rest >> 1;
        if (rest != 0) pw = (pw * pw) % m;
      end
      return word_t'(acc);
    endfunction

    function void note_input(word_t b, word_t e);
      expected_q.push_back(expected_power(b, e));
    endfunction

    function void check_result(word_t r);
      word_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("mismatch: result %0d with nothing expected", r);
        return;
      end
      want = expected_q.pop_front();
      if (r !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: result expected %0d got %0d (modulus %0d)", want, r, modulus);
      end
    endfunction
  endclass

  logic  clk;
  logic  rst;
  logic  modulus_we;
  word_t modulus_wdata;
  logic  in_valid;
  logic  in_stall;
  word_t base;
  word_t exponent;
  logic  out_valid;
  logic  out_stall;
  word_t result;

  power_board board = new();
  bit         steady;

  modular_exponentiation i_dut (
    .clk           (clk),
    .rst           (rst),
    .modulus_we    (modulus_we),
    .modulus_wdata (modulus_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .base          (base),
    .exponent      (exponent),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result        (result)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  initial begin
    #60_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // idle length: mostly short, now and then long
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 6) == 0) return $urandom_range(10, 60);
    return $urandom_range(1, 3);
  endfunction

  // exponent with a random bit length, mostly short to keep the run quick
  function automatic word_t pick_exponent();
    int unsigned     bits;
    longint unsigned tmp;
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2, 3, 4: bits = $urandom_range(13, DATA_W);
      default: bits = $urandom_range(1, 12);
    endcase
    tmp = {$urandom, $urandom} & ((64'd1 << bits) - 1);
    tmp[bits-1] = 1'b1;
    return word_t'(tmp);
  endfunction

  // base mostly below the modulus, sometimes at the edges or unreduced
  function automatic word_t pick_base(word_t m);
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return word_t'(1);
          2:       return m - 1;
          default: return '1;
        endcase
      end
      1:       return word_t'($urandom);
      default: return (m >= 2) ? word_t'($urandom % m) : word_t'($urandom);
    endcase
  endfunction

  // receiver side: random stalls unless in a quiet stretch
  initial begin
    int unsigned n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!steady && $urandom_range(0, 2) == 0) begin
        out_stall = 1'b1;
        n = idle_len();
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // result monitor
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) board.check_result(result);
    end
  end

  // present one item and hold it until it is taken
  task automatic send_item(word_t b, word_t e);
    @(negedge clk);
    in_valid = 1'b1;
    base     = b;
    exponent = e;
    do @(posedge clk); while (in_stall);
    board.note_input(b, e);
  endtask

  // item followed by an optional gap on the input side
  task automatic send_and_idle(word_t b, word_t e);
    int unsigned n;
    send_item(b, e);
    if (!steady && $urandom_range(0, 2) == 0) begin
      n = idle_len();
      @(negedge clk);
      in_valid = 1'b0;
      base     = word_t'($urandom);
      exponent = word_t'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // modulus write once every outstanding result is back
  task automatic write_modulus(word_t value);
    @(negedge clk);
    in_valid = 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    modulus_we    = 1'b1;
    modulus_wdata = value;
    @(negedge clk);
    modulus_we    = 1'b0;
    modulus_wdata = word_t'($urandom);
    board.set_modulus(value);
  endtask

  // random items under the current modulus
  task automatic run_phase(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 20 == 0) steady = ($urandom_range(0, 3) == 0);
      send_and_idle(pick_base(board.modulus), pick_exponent());
    end
  endtask

  initial begin
    rst           = 1'b1;
    modulus_we    = 1'b0;
    modulus_wdata = '0;
    in_valid      = 1'b0;
    base          = '0;
    exponent      = '0;
    steady        = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed items under the reset modulus
    send_and_idle('0, '0);
    send_and_idle('0, word_t'(1));
    send_and_idle(word_t'(1), '1);
    send_and_idle('1, '1);
    send_and_idle('1, '0);
    send_and_idle(word_t'(1000000006), word_t'(2));
    send_and_idle(word_t'(2), word_t'(30));
    send_and_idle(word_t'(1000000007), word_t'(5));
    send_and_idle(word_t'(1000000008), word_t'(3));
    send_and_idle(word_t'(12345), word_t'(1));
    send_and_idle(word_t'(2147483646), '0);
    send_and_idle(word_t'(31'h5555_5555), word_t'(31'h2AAA_AAAA));
    send_and_idle(word_t'(31'h2AAA_AAAA), word_t'(31'h5555_5555));
    send_and_idle(word_t'(3), word_t'(1000000006));
    send_and_idle(word_t'(2), word_t'(31'h4000_0000));
    run_phase(34);

    // smallest meaningful modulus, then the largest
    write_modulus(word_t'(2));
    send_and_idle('1, '0);
    run_phase(30);
    write_modulus('1);
    send_and_idle(word_t'(2147483646), '1);
    send_and_idle('1, word_t'(7));
    run_phase(40);

    // degenerate moduli: every result is zero
    write_modulus(word_t'(1));
    send_and_idle(word_t'(5), '0);
    run_phase(10);
    write_modulus('0);
    send_and_idle('0, '0);
    send_and_idle('1, '1);
    run_phase(10);

    // small, random and large moduli, then back to the reset value
    write_modulus(word_t'(3));
    run_phase(25);
    write_modulus(word_t'($urandom_range(4, 1000)));
    run_phase(40);
    write_modulus(word_t'({1'b1, 30'($urandom)}));
    run_phase(40);
    write_modulus(MOD_RESET);
    run_phase(40);

    // drain and watch for stray results
    @(negedge clk);
    in_valid = 1'b0;
    for (int i = 0; i < 20000 && board.expected_q.size() > 0; i++) @(posedge clk);
    repeat (200) @(posedge clk);
    board.errors += board.expected_q.size();

    if (board.errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
src/mme_pkg.sv
src/mme_mulmod.sv
src/mme_seq.sv
src/modular_exponentiation.sv
src/mme_checker.sv
sim/tb_top.sv
